>>> design/mecanum_key_drive_controller_unit_assert.svh
// assertion macros for the mecanum key drive controller
// expects clk and rst_n in the scope where a macro is used
`ifndef MECANUM_KEY_DRIVE_CONTROLLER_UNIT_ASSERT_SVH
`define MECANUM_KEY_DRIVE_CONTROLLER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MKDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mkdc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define MKDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkdc: next-cycle check failed");

`endif

>>> design/mkdc_pkg.sv
// shared types, codes and helper functions for the mecanum key drive controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mkdc_pkg;

  // request types on the input side
  localparam logic [1:0] REQ_HOST = 2'd0;
  localparam logic [1:0] REQ_COMP = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED_STEP  = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_DRIVE_LIMIT = 2'd2;
  localparam logic [1:0] REG_SPIN_TICKS  = 2'd3;

  // character codes
  localparam logic [7:0] CH_LW   = 8'h77;  // w
  localparam logic [7:0] CH_LX   = 8'h78;  // x
  localparam logic [7:0] CH_LA   = 8'h61;  // a
  localparam logic [7:0] CH_LD   = 8'h64;  // d
  localparam logic [7:0] CH_LQ   = 8'h71;  // q
  localparam logic [7:0] CH_LE   = 8'h65;  // e
  localparam logic [7:0] CH_LS   = 8'h73;  // s
  localparam logic [7:0] CH_LI   = 8'h69;  // i
  localparam logic [7:0] CH_LU   = 8'h75;  // u
  localparam logic [7:0] CH_LO   = 8'h6F;  // o
  localparam logic [7:0] CH_LK   = 8'h6B;  // k
  localparam logic [7:0] CH_UK   = 8'h4B;  // K
  localparam logic [7:0] CH_LP   = 8'h70;  // p
  localparam logic [7:0] CH_UP   = 8'h50;  // P
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // stream widths
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;

  // command queue depth
  localparam int QDEPTH = 2;

  // reset values of the configuration registers
  localparam logic [9:0]  RST_SPEED_STEP  = 10'd400;
  localparam logic [9:0]  RST_SPEED_LIMIT = 10'd400;
  localparam logic [9:0]  RST_DRIVE_LIMIT = 10'd999;
  localparam logic [19:0] RST_SPIN_TICKS  = 20'd10000;

  localparam logic [9:0]  ENTRY_MAX   = 10'd999;
  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

  // spin servo pulses in microseconds
  localparam logic [10:0] PULSE_CCW  = 11'd1000;
  localparam logic [10:0] PULSE_STOP = 11'd1500;
  localparam logic [10:0] PULSE_CW   = 11'd2000;

  // syringe angle kept as a step index: 5, 40, 75, 110, 145 degrees
  localparam logic [2:0] SYR_FIRST = 3'd0;
  localparam logic [2:0] SYR_LAST  = 3'd4;

  typedef enum logic [1:0] {
    SPIN_STOP = 2'd0,
    SPIN_CCW  = 2'd1,
    SPIN_CW   = 2'd2
  } spin_t;

  // classified key or event
  typedef enum logic [4:0] {
    K_NOP, K_TICK, K_W, K_X, K_A, K_D, K_Q, K_E, K_S,
    K_I, K_U, K_O, K_K, K_P, K_EOL, K_DIGIT, K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       host;   // byte came from the host link
    logic [3:0] digit;  // digit value for K_DIGIT
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic       fwd;
    logic [9:0] duty;
  } wheel_t;

  // clamp a stepped speed to +-lim
  function automatic logic signed [10:0] sym_limit(input logic signed [11:0] v,
                                                   input logic [9:0] lim);
    logic signed [11:0] l;
    logic signed [11:0] nl;
    logic signed [11:0] c;
    l  = signed'({2'b00, lim});
    nl = -l;
    c  = v;
    if (v > l) c = l;
    else if (v < nl) c = nl;
    return signed'(c[10:0]);
  endfunction

  // clamp a wheel mix to +-lim and split into direction and duty
  function automatic wheel_t wheel_mix(input logic signed [12:0] m,
                                       input logic [9:0] lim);
    logic signed [12:0] l;
    logic signed [12:0] nl;
    logic signed [12:0] c;
    logic signed [12:0] a;
    wheel_t w;
    l  = signed'({3'b000, lim});
    nl = -l;
    c  = m;
    if (m > l) c = l;
    else if (m < nl) c = nl;
    a = (c < 13'sd0) ? -c : c;
    w.fwd  = (c > 13'sd0);
    w.duty = a[9:0];
    return w;
  endfunction

  // 500 + angle * 2000 / 180, truncated
  function automatic logic [11:0] syringe_pulse(input logic [2:0] idx);
    logic [11:0] p;
    case (idx)
      3'd0:    p = 12'd555;
      3'd1:    p = 12'd944;
      3'd2:    p = 12'd1333;
      3'd3:    p = 12'd1722;
      3'd4:    p = 12'd2111;
      default: p = 12'd555;
    endcase
    return p;
  endfunction

endpackage

>>> design/mecanum_key_drive_controller_unit.sv
// top level of the mecanum key drive controller
// depends on mkdc_pkg, mkdc_front, mkdc_queue, mkdc_back and the assertion header
`timescale 1ns / 1ps
`include "mecanum_key_drive_controller_unit_assert.svh"

// Takes host bytes, companion bytes and millisecond ticks on one stream and
// returns one result per request: four mecanum wheel directions and duties,
// the spin and syringe servo pulses, the entry flag and the last numeric entry.
// Sustained rate is one request per clock while out_tready stays high; the
// back end pops each command from a two-entry command queue, updates the whole
// controller state from it and formats the result from the updated registers
// into a registered output. Configuration writes take effect at once.
module mecanum_key_drive_controller_unit
  import mkdc_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [19:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] fl fwd, [10:1] fl duty, [11] fr fwd, [21:12] fr duty,
  // [22] rl fwd, [32:23] rl duty, [33] rr fwd, [43:34] rr duty,
  // [54:44] spin_pulse, [66:55] syringe_pulse, [67] entry_mode,
  // [77:68] speed_setting, [79:78] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  cmd_t   q_din;
  qhead_t q_head;

  // classify incoming requests
  mkdc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .cmd       (q_din)
  );

  // command queue
  mkdc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .full  (q_full),
    .head  (q_head)
  );

  // execution and result formatting
  mkdc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // the back end only executes a queued command
  `MKDC_ASSERT_NOW(a_pop_has_cmd, q_pop, q_head.valid)
  // an accepted request is queued in the next cycle
  `MKDC_ASSERT_NEXT(a_push_lands, in_tvalid && in_tready, q_head.valid)
  // back-pressure only comes from a queue holding commands
  `MKDC_ASSERT_NOW(a_stall_nonempty, !in_tready, q_head.valid)

endmodule

>>> design/mkdc_front.sv
// front end: accepts input requests and classifies them into commands
// depends on mkdc_pkg; pushes into mkdc_queue
`timescale 1ns / 1ps

module mkdc_front
  import mkdc_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,  // [7:0] rx_byte
  input  logic [IN_USER_W-1:0] in_tuser,  // [1:0] req_type
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 cmd
);

  kind_t key_kind;

  // accept whenever the queue has room
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // byte to key class
  always_comb begin
    key_kind = K_OTHER;
    if (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) begin
      key_kind = K_DIGIT;
    end else begin
      case (in_tdata)
        CH_LW:        key_kind = K_W;
        CH_LX:        key_kind = K_X;
        CH_LA:        key_kind = K_A;
        CH_LD:        key_kind = K_D;
        CH_LQ:        key_kind = K_Q;
        CH_LE:        key_kind = K_E;
        CH_LS:        key_kind = K_S;
        CH_LI:        key_kind = K_I;
        CH_LU:        key_kind = K_U;
        CH_LO:        key_kind = K_O;
        CH_LK, CH_UK: key_kind = K_K;
        CH_LP, CH_UP: key_kind = K_P;
        CH_CR, CH_LF: key_kind = K_EOL;
        default:      key_kind = K_OTHER;
      endcase
    end
  end

  // request type selects byte, tick or no-op
  always_comb begin
    cmd.host  = (in_tuser == REQ_HOST);
    cmd.digit = in_tdata[3:0];
    case (in_tuser)
      REQ_HOST, REQ_COMP: cmd.kind = key_kind;
      REQ_TICK:           cmd.kind = K_TICK;
      default:            cmd.kind = K_NOP;
    endcase
  end

endmodule

>>> design/mkdc_queue.sv
// short command queue between the front and back ends
// depends on mkdc_pkg for the command type and depth
`timescale 1ns / 1ps

module mkdc_queue
  import mkdc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   din,
  input  logic   pop,
  output logic   full,
  output qhead_t head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

>>> design/mkdc_back.sv
// back end: executes commands on the controller state and formats results
// depends on mkdc_pkg; pops from mkdc_queue, drives the result stream
`timescale 1ns / 1ps

module mkdc_back
  import mkdc_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [19:0]           cfg_wdata,
  input  qhead_t                head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int DCW = $clog2(MAX_DIGITS + 1);

  // configuration
  logic [9:0]  step_r, slim_r, dlim_r;
  logic [19:0] run_ticks_r;

  // controller state
  logic               entry_r, entry_nxt;
  logic [9:0]         dval_r, dval_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DCW-1:0]     dcnt_r, dcnt_nxt;
  logic signed [10:0] fwd_r, fwd_nxt;
  logic signed [10:0] side_r, side_nxt;
  logic signed [10:0] turn_r, turn_nxt;
  spin_t              spin_r, spin_nxt;
  logic               run_r, run_nxt;
  logic [19:0]        elapsed_r, elapsed_nxt;
  logic [2:0]         syr_r, syr_nxt;
  logic [9:0]         acc_r, acc_nxt;

  // pipeline control
  logic pend_r, pend_nxt;
  logic ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic fmt_go;

  // decode helpers
  cmd_t               c;
  logic               drive;
  logic               start;
  logic signed [11:0] st;
  logic signed [11:0] f_d, s_d, t_d;
  logic signed [11:0] f_sum, s_sum, t_sum;
  logic [13:0]        nv;

  // result formatting
  logic signed [12:0] fe, se, te;
  wheel_t             fl, fr, rl, rr;
  logic [10:0]        spin_pulse;

  // pipeline handshakes
  assign fmt_go = pend_r && (!ov_r || out_tready);
  assign pop    = head.valid && (!pend_r || fmt_go);
  assign c      = head.cmd;

  assign out_tvalid = ov_r;
  assign out_tdata  = out_data_r;

  // drive keys apply in driving mode from either link, 'p' on host opens entry
  always_comb begin
    start = 1'b0;
    drive = 1'b0;
    if (!entry_r && c.kind != K_TICK && c.kind != K_NOP) begin
      if (c.host && c.kind == K_P) start = 1'b1;
      else drive = 1'b1;
    end
  end

  // speed stepping
  always_comb begin
    st  = signed'({2'b00, step_r});
    f_d = '0;
    s_d = '0;
    t_d = '0;
    case (c.kind)
      K_W:     f_d = -st;
      K_X:     f_d = st;
      K_A:     s_d = -st;
      K_D:     s_d = st;
      K_Q:     t_d = -st;
      K_E:     t_d = st;
      default: f_d = '0;
    endcase
    f_sum = 12'(fwd_r) + f_d;
    s_sum = 12'(side_r) + s_d;
    t_sum = 12'(turn_r) + t_d;
    if (c.kind == K_S) begin
      f_sum = '0;
      s_sum = '0;
      t_sum = '0;
    end
    fwd_nxt  = fwd_r;
    side_nxt = side_r;
    turn_nxt = turn_r;
    if (start) begin
      fwd_nxt  = '0;
      side_nxt = '0;
      turn_nxt = '0;
    end else if (drive) begin
      fwd_nxt  = sym_limit(f_sum, slim_r);
      side_nxt = sym_limit(s_sum, slim_r);
      turn_nxt = sym_limit(t_sum, slim_r);
    end
  end

  // numeric entry
  always_comb begin
    entry_nxt = entry_r;
    dval_nxt  = dval_r;
    ovf_nxt   = ovf_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    nv        = {1'b0, dval_r, 3'b000} + {3'b000, dval_r, 1'b0} + {10'd0, c.digit};
    if (start) begin
      entry_nxt = 1'b1;
      dval_nxt  = '0;
      ovf_nxt   = 1'b0;
      dcnt_nxt  = '0;
    end else if (entry_r && c.host) begin
      if (c.kind == K_EOL) begin
        if (!ovf_r) acc_nxt = dval_r;
        entry_nxt = 1'b0;
      end else if (c.kind == K_DIGIT && dcnt_r < DCW'(MAX_DIGITS)) begin
        if (ovf_r || nv > {4'd0, ENTRY_MAX}) ovf_nxt = 1'b1;
        else dval_nxt = nv[9:0];
        dcnt_nxt = dcnt_r + 1'b1;
      end
    end
  end

  // spin servo and syringe
  always_comb begin
    spin_nxt    = spin_r;
    run_nxt     = run_r;
    elapsed_nxt = elapsed_r;
    syr_nxt     = syr_r;
    if (drive) begin
      case (c.kind)
        K_I: begin
          if (!run_r) begin
            spin_nxt    = SPIN_CW;
            run_nxt     = 1'b1;
            elapsed_nxt = '0;
          end
        end
        K_U: begin
          spin_nxt = SPIN_CCW;
          run_nxt  = 1'b0;
        end
        K_O: begin
          spin_nxt = SPIN_CW;
          run_nxt  = 1'b0;
        end
        K_K: begin
          syr_nxt = (syr_r == SYR_LAST) ? SYR_FIRST : syr_r + 1'b1;
        end
        default: spin_nxt = spin_r;
      endcase
    end
    if (c.kind == K_TICK && run_r && elapsed_r != ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
    // auto stop after every event
    if (run_nxt && elapsed_nxt >= run_ticks_r) begin
      spin_nxt = SPIN_STOP;
      run_nxt  = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= RST_SPEED_STEP;
      slim_r      <= RST_SPEED_LIMIT;
      dlim_r      <= RST_DRIVE_LIMIT;
      run_ticks_r <= RST_SPIN_TICKS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SPEED_STEP:  step_r      <= cfg_wdata[9:0];
        REG_SPEED_LIMIT: slim_r      <= cfg_wdata[9:0];
        REG_DRIVE_LIMIT: dlim_r      <= cfg_wdata[9:0];
        REG_SPIN_TICKS:  run_ticks_r <= cfg_wdata;
        default:         step_r      <= step_r;
      endcase
    end
  end

  // state update on each popped command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r   <= 1'b0;
      dval_r    <= '0;
      ovf_r     <= 1'b0;
      dcnt_r    <= '0;
      fwd_r     <= '0;
      side_r    <= '0;
      turn_r    <= '0;
      spin_r    <= SPIN_STOP;
      run_r     <= 1'b0;
      elapsed_r <= '0;
      syr_r     <= SYR_FIRST;
      acc_r     <= '0;
    end else if (pop) begin
      entry_r   <= entry_nxt;
      dval_r    <= dval_nxt;
      ovf_r     <= ovf_nxt;
      dcnt_r    <= dcnt_nxt;
      fwd_r     <= fwd_nxt;
      side_r    <= side_nxt;
      turn_r    <= turn_nxt;
      spin_r    <= spin_nxt;
      run_r     <= run_nxt;
      elapsed_r <= elapsed_nxt;
      syr_r     <= syr_nxt;
      acc_r     <= acc_nxt;
    end
  end

  // wheel mixes from the state left by the last executed command
  always_comb begin
    fe = 13'(fwd_r);
    se = 13'(side_r);
    te = 13'(turn_r);
    fl = wheel_mix(fe - se - te, dlim_r);
    fr = wheel_mix(fe + se + te, dlim_r);
    rl = wheel_mix(fe + se - te, dlim_r);
    rr = wheel_mix(fe - se + te, dlim_r);
    case (spin_r)
      SPIN_CCW: spin_pulse = PULSE_CCW;
      SPIN_CW:  spin_pulse = PULSE_CW;
      default:  spin_pulse = PULSE_STOP;
    endcase
  end

  // pending-format flag and output register valid
  always_comb begin
    pend_nxt = pend_r;
    if (pop) pend_nxt = 1'b1;
    else if (fmt_go) pend_nxt = 1'b0;
    ov_nxt = ov_r;
    if (fmt_go) ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fmt_go) begin
      out_data_r <= {2'b00, acc_r, entry_r, syringe_pulse(syr_r), spin_pulse,
                     rr.duty, rr.fwd, rl.duty, rl.fwd,
                     fr.duty, fr.fwd, fl.duty, fl.fwd};
    end
  end

endmodule

>>> tb/tb.sv
// self-checking testbench for the mecanum key drive controller unit
// drives host bytes, companion bytes and ticks, predicts every result; needs mkdc_pkg
`timescale 1ns / 1ps

module tb;
  import mkdc_pkg::*;

  localparam logic [1:0] REQ_NONE     = 2'd3;  // request type with no meaning
  localparam int         ENTRY_DIGITS = 9;
  localparam int         SYR_STEP_DEG = 35;
  localparam int         SYR_MAX_DEG  = 145;
  localparam int         SYR_MIN_DEG  = 5;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         PRINT_CAP    = 100;

  // one result as seen on out_tdata; wheels 0..3 are fl, fr, rl, rr
  typedef struct packed {
    logic [3:0]      fwd;
    logic [3:0][9:0] duty;
    logic [10:0]     spin_us;
    logic [11:0]     syringe_us;
    logic            entry_on;
    logic [9:0]      kept_speed;
    logic [1:0]      pad;
  } drive_result_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [1:0]            cfg_addr   = '0;
  logic [19:0]           cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [7:0] rx_byte
  logic [IN_USER_W-1:0]  in_tuser   = '0;  // [1:0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // wheels 11 bits each from bit 0, then servos

  // predicted controller state and register copies
  int    cfg_step, cfg_limit, cfg_drive, cfg_ticks;
  bit    st_entry, st_overflow, st_spin_on;
  int    st_digits, st_count, st_fwd, st_side, st_turn, st_spin_ms, st_angle, st_kept;
  spin_t st_spin;

  drive_result_t predicted_outputs[$];
  bit    bursts_on = 1'b1;
  int    sent_count, results_checked, mismatches, kept_entries, auto_stops;
  int    quiet_cycles;
  string wheel_name[4] = '{"front left", "front right", "rear left", "rear right"};

  mecanum_key_drive_controller_unit #(
    .MAX_DIGITS(ENTRY_DIGITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one drive key from either link, speeds re-clamped afterwards
  function automatic void apply_key(logic [7:0] code);
    case (code)
      CH_LW: st_fwd -= cfg_step;
      CH_LX: st_fwd += cfg_step;
      CH_LA: st_side -= cfg_step;
      CH_LD: st_side += cfg_step;
      CH_LQ: st_turn -= cfg_step;
      CH_LE: st_turn += cfg_step;
      CH_LS: begin
        st_fwd = 0;
        st_side = 0;
        st_turn = 0;
      end
      CH_LI: begin
        if (!st_spin_on) begin
          st_spin = SPIN_CW;
          st_spin_on = 1'b1;
          st_spin_ms = 0;
        end
      end
      CH_LU: begin
        st_spin = SPIN_CCW;
        st_spin_on = 1'b0;
      end
      CH_LO: begin
        st_spin = SPIN_CW;
        st_spin_on = 1'b0;
      end
      CH_LK, CH_UK: begin
        st_angle += SYR_STEP_DEG;
        if (st_angle > SYR_MAX_DEG) st_angle = SYR_MIN_DEG;
      end
      default: ;
    endcase
    st_fwd  = clamp_sym(st_fwd, cfg_limit);
    st_side = clamp_sym(st_side, cfg_limit);
    st_turn = clamp_sym(st_turn, cfg_limit);
  endfunction

  // advance the controller by one request and return the outputs it shows
  function automatic drive_result_t advance_controller(logic [1:0] kind, logic [7:0] code);
    drive_result_t r;
    int mix[4];
    int c;
    int nv;
    case (kind)
      REQ_HOST: begin
        if (st_entry) begin
          if (code == CH_CR || code == CH_LF) begin
            if (!st_overflow) begin
              st_kept = st_digits;
              kept_entries++;
            end
            st_entry = 1'b0;
          end else if (st_count < ENTRY_DIGITS && code >= CH_ZERO && code <= CH_NINE) begin
            nv = st_digits * 10 + int'(code - CH_ZERO);
            if (st_overflow || nv > int'(ENTRY_MAX)) st_overflow = 1'b1;
            else st_digits = nv;
            st_count++;
          end
        end else if (code == CH_LP || code == CH_UP) begin
          st_fwd = 0;
          st_side = 0;
          st_turn = 0;
          st_entry = 1'b1;
          st_digits = 0;
          st_overflow = 1'b0;
          st_count = 0;
        end else begin
          apply_key(code);
        end
      end
      REQ_COMP: if (!st_entry) apply_key(code);
      REQ_TICK: if (st_spin_on && st_spin_ms < int'(ELAPSED_MAX)) st_spin_ms++;
      default: ;
    endcase
    // timed spin stop is looked at after every request
    if (st_spin_on && st_spin_ms >= cfg_ticks) begin
      st_spin = SPIN_STOP;
      st_spin_on = 1'b0;
      auto_stops++;
    end

    mix[0] = st_fwd - st_side - st_turn;
    mix[1] = st_fwd + st_side + st_turn;
    mix[2] = st_fwd + st_side - st_turn;
    mix[3] = st_fwd - st_side + st_turn;
    for (int w = 0; w < 4; w++) begin
      c = clamp_sym(mix[w], cfg_drive);
      r.fwd[w]  = (c > 0);
      r.duty[w] = 10'((c < 0) ? -c : c);
    end
    case (st_spin)
      SPIN_CCW: r.spin_us = PULSE_CCW;
      SPIN_CW:  r.spin_us = PULSE_CW;
      default:  r.spin_us = PULSE_STOP;
    endcase
    r.syringe_us = 12'((st_angle * 2000) / 180 + 500);
    r.entry_on   = st_entry;
    r.kept_speed = 10'(st_kept);
    r.pad        = '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [11:0] got,
                                 input logic [11:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at result %0d: %s is %0d, expected %0d",
               results_checked, what, got, want);
    mismatches++;
  endtask

  // send one request, with an optional gap in front of it
  task automatic send_request(input logic [1:0] kind, input logic [7:0] code);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    predicted_outputs.push_back(advance_controller(kind, code));
    sent_count++;
  endtask

  task automatic put_reg(input logic [1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 20'(value);
    @(posedge clk);
  endtask

  // registers change only once the block has drained
  task automatic apply_settings(input int step, input int limit, input int drive,
                                input int ticks);
    in_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    put_reg(REG_SPEED_STEP, step);
    put_reg(REG_SPEED_LIMIT, limit);
    put_reg(REG_DRIVE_LIMIT, drive);
    put_reg(REG_SPIN_TICKS, ticks);
    cfg_we    <= 1'b0;
    cfg_step  = step;
    cfg_limit = limit;
    cfg_drive = drive;
    cfg_ticks = ticks;
  endtask

  // result check
  always @(posedge clk) begin
    drive_result_t got;
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      for (int w = 0; w < 4; w++) begin
        got.fwd[w]  = out_tdata[w*11];
        got.duty[w] = out_tdata[w*11+1 +: 10];
      end
      got.spin_us    = out_tdata[54:44];
      got.syringe_us = out_tdata[66:55];
      got.entry_on   = out_tdata[67];
      got.kept_speed = out_tdata[77:68];
      got.pad        = out_tdata[79:78];
      if (predicted_outputs.size() == 0) begin
        report_mismatch("result with nothing pending, valid", 12'd1, 12'd0);
      end else begin
        want = predicted_outputs.pop_front();
        for (int w = 0; w < 4; w++) begin
          if (got.fwd[w] !== want.fwd[w])
            report_mismatch({wheel_name[w], " direction"}, 12'(got.fwd[w]),
                            12'(want.fwd[w]));
          if (got.duty[w] !== want.duty[w])
            report_mismatch({wheel_name[w], " duty"}, 12'(got.duty[w]),
                            12'(want.duty[w]));
        end
        if (got.spin_us !== want.spin_us)
          report_mismatch("spin pulse", 12'(got.spin_us), 12'(want.spin_us));
        if (got.syringe_us !== want.syringe_us)
          report_mismatch("syringe pulse", got.syringe_us, want.syringe_us);
        if (got.entry_on !== want.entry_on)
          report_mismatch("entry mode", 12'(got.entry_on), 12'(want.entry_on));
        if (got.kept_speed !== want.kept_speed)
          report_mismatch("speed setting", 12'(got.kept_speed), 12'(want.kept_speed));
        if (got.pad !== want.pad)
          report_mismatch("padding bits", 12'(got.pad), 12'(want.pad));
      end
      results_checked++;
    end
  end

  // result side backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 quiet_cycles, predicted_outputs.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_drive_key();
    case ($urandom_range(0, 11))
      0:       return CH_LW;
      1:       return CH_LX;
      2:       return CH_LA;
      3:       return CH_LD;
      4:       return CH_LQ;
      5:       return CH_LE;
      6:       return CH_LS;
      7:       return CH_LI;
      8:       return CH_LU;
      9:       return CH_LO;
      10:      return CH_LK;
      default: return CH_UK;
    endcase
  endfunction

  function automatic int pick_limit_value();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 999;
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic int pick_run_time();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1000000;
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  task automatic send_noise();
    send_request(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic send_key_burst();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 4) == 0) send_request(REQ_TICK, 8'($urandom));
      else send_request($urandom_range(0, 1) ? REQ_HOST : REQ_COMP, pick_drive_key());
    end
  endtask

  // numeric entry with random digits, stray bytes and an occasional missing end
  task automatic send_entry_sequence();
    int ndig;
    send_request(REQ_HOST, $urandom_range(0, 1) ? CH_LP : CH_UP);
    case ($urandom_range(0, 7))
      0:       ndig = 0;
      1:       ndig = $urandom_range(4, 11);
      default: ndig = $urandom_range(1, 3);
    endcase
    for (int i = 0; i < ndig; i++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_request(REQ_HOST, CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 15) != 0)
      send_request(REQ_HOST, $urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic send_spin_run();
    if ($urandom_range(0, 3) != 0)
      send_request($urandom_range(0, 1) ? REQ_HOST : REQ_COMP, CH_LI);
    repeat ($urandom_range(1, 24)) send_request(REQ_TICK, 8'($urandom));
  endtask

  // reset values, meaningless request type, tick with nothing running
  task automatic test_reset_state();
    send_request(REQ_NONE, 8'hFF);
    send_request(REQ_TICK, 8'h00);
  endtask

  // stepping, speed clamp, drive clamp and both links
  task automatic test_wheel_mixing();
    apply_settings(400, 400, 999, 3);
    send_request(REQ_HOST, CH_LW);
    send_request(REQ_HOST, CH_LW);
    send_request(REQ_COMP, CH_LD);
    send_request(REQ_HOST, CH_LE);
    send_request(REQ_COMP, CH_LQ);
    send_request(REQ_HOST, CH_LX);
    send_request(REQ_HOST, CH_LA);
    send_request(REQ_HOST, CH_LS);
  endtask

  // spin run with 'i' ignored while running, timed stop, both syringe keys
  task automatic test_servos();
    send_request(REQ_HOST, CH_LI);
    send_request(REQ_TICK, 8'hA5);
    send_request(REQ_HOST, CH_LI);
    send_request(REQ_TICK, 8'h5A);
    send_request(REQ_TICK, 8'h00);
    send_request(REQ_COMP, CH_LU);
    send_request(REQ_HOST, CH_LO);
    send_request(REQ_HOST, CH_LK);
    send_request(REQ_COMP, CH_UK);
    // zero run time stops in the same request
    apply_settings(400, 400, 999, 0);
    send_request(REQ_HOST, CH_LI);
  endtask

  // entry zeroes speeds, ignores companion and stray bytes, overflow, empty entry
  task automatic test_speed_entry();
    send_request(REQ_COMP, CH_LX);
    send_request(REQ_HOST, CH_LP);
    send_request(REQ_COMP, CH_ZERO + 8'd7);
    send_request(REQ_HOST, CH_ZERO + 8'd4);
    send_request(REQ_HOST, 8'h7A);
    send_request(REQ_HOST, CH_ZERO + 8'd2);
    send_request(REQ_HOST, CH_LF);
    send_request(REQ_HOST, CH_UP);
    send_request(REQ_HOST, CH_ZERO + 8'd5);
    repeat (3) send_request(REQ_HOST, CH_ZERO);
    send_request(REQ_HOST, CH_CR);
    send_request(REQ_HOST, CH_LP);
    send_request(REQ_HOST, CH_CR);
  endtask

  // register extremes; a lower limit only bites on the next key
  task automatic test_limit_changes();
    apply_settings(999, 999, 0, 1000000);
    send_request(REQ_HOST, CH_LD);
    send_request(REQ_COMP, CH_LE);
    send_request(REQ_HOST, CH_LW);
    apply_settings(0, 500, 999, 10000);
    send_request(REQ_TICK, 8'hFF);
    send_request(REQ_HOST, 8'h23);
    send_request(REQ_COMP, CH_LW);
  endtask

  // phases of random traffic under random settings, last phase without gaps
  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < 8; phase++) begin
      apply_settings(pick_limit_value(), pick_limit_value(), pick_limit_value(),
                     pick_run_time());
      if (phase == 7) bursts_on = 1'b0;
      goal = sent_count + 160;
      while (sent_count < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_key_burst();
          4, 5:       send_entry_sequence();
          6, 7:       send_spin_run();
          default:    send_noise();
        endcase
      end
    end
  endtask

  initial begin
    cfg_step    = int'(RST_SPEED_STEP);
    cfg_limit   = int'(RST_SPEED_LIMIT);
    cfg_drive   = int'(RST_DRIVE_LIMIT);
    cfg_ticks   = int'(RST_SPIN_TICKS);
    st_entry    = 1'b0;
    st_overflow = 1'b0;
    st_spin_on  = 1'b0;
    st_digits   = 0;
    st_count    = 0;
    st_fwd      = 0;
    st_side     = 0;
    st_turn     = 0;
    st_spin     = SPIN_STOP;
    st_spin_ms  = 0;
    st_angle    = SYR_MIN_DEG;
    st_kept     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_wheel_mixing();
    test_servos();
    test_speed_entry();
    test_limit_changes();
    test_random_traffic();

    // drain, then a short tail to catch stray results
    in_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("summary: %0d requests sent, %0d results checked, %0d mismatches",
             sent_count, results_checked, mismatches);
    $display("summary: %0d numeric entries kept, %0d timed spin stops",
             kept_entries, auto_stops);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
